// ===== src/sqp_pkg.sv =====
// Shared constants and types for the sorted minimum priority queue.
// No dependencies; imported by sqp_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none
package sqp_pkg;

  localparam int DEPTH          = 16;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int KEY_W          = 14;
  localparam int OCC_W          = 5;
  localparam int FIELD_W        = 7;
  localparam int STATION_WEIGHT = 100;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] popped_key;
    logic             was_empty;
    logic             push_dropped;
    logic [OCC_W-1:0] occupancy;
  } sqp_result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } sqp_ram_req_t;

endpackage
`default_nettype wire

// ===== src/sqp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sqp_ctrl.sv =====
// Sequencer for the queue: forms the key, then walks the key RAM one cell at a
// time, reading it and then doing a single compare and move. Depends on sqp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sqp_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            op,
  input  wire logic [sqp_pkg::FIELD_W-1:0]     station_number,
  input  wire logic [sqp_pkg::FIELD_W-1:0]     item_number,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output sqp_pkg::sqp_result_t                 res,
  output sqp_pkg::sqp_ram_req_t                ram_req,
  input  wire logic [sqp_pkg::KEY_W-1:0]       ram_rdata
);
  import sqp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_PUT  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]       state;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ins;
  logic [CNT_W-1:0] count;
  logic [KEY_W-1:0] key;
  logic             is_pop;
  logic [KEY_W-1:0] popped;
  logic             empty;
  logic             dropped;

  logic [KEY_W-1:0] key_prod;
  logic [KEY_W-1:0] key_new;
  logic             accept;
  logic             last_cell;
  logic             move_up;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign key_prod  = KEY_W'(station_number) * KEY_W'(STATION_WEIGHT);
  assign key_new   = key_prod + KEY_W'(item_number);
  assign last_cell = (CNT_W'(idx) == count - CNT_W'(1));
  assign move_up   = (ram_rdata >= key);

  // RAM read address and the write, if any, picked by the state
  always_comb begin
    ram_req.raddr = idx;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx;
    ram_req.wdata = ram_rdata;
    case (state)
      ST_CMP: begin
        if (!is_pop) begin
          ram_req.we    = move_up;
          ram_req.waddr = idx + IDX_W'(1);
        end else begin
          ram_req.we    = (idx != '0);
          ram_req.waddr = idx - IDX_W'(1);
        end
      end
      ST_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ins;
        ram_req.wdata = key;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key     <= key_new;
            is_pop  <= (op == OP_POP);
            popped  <= '0;
            empty   <= 1'b0;
            dropped <= 1'b0;
            idx     <= '0;
            ins     <= '0;
            if (op == OP_POP) begin
              if (count == '0) begin
                empty <= 1'b1;
                state <= ST_OUT;
              end else begin
                state <= ST_RD;
              end
            end else if (count == CNT_W'(DEPTH)) begin
              dropped <= 1'b1;
              state   <= ST_OUT;
            end else if (count == '0) begin
              state <= ST_PUT;
            end else begin
              idx   <= IDX_W'(count - CNT_W'(1));
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!is_pop) begin
            if (!move_up) begin
              ins   <= idx + IDX_W'(1);
              state <= ST_PUT;
            end else if (idx == '0) begin
              ins   <= '0;
              state <= ST_PUT;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= ST_RD;
            end
          end else begin
            if (idx == '0) begin
              popped <= ram_rdata;
            end
            if (last_cell) begin
              count <= count - CNT_W'(1);
              state <= ST_OUT;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= ST_RD;
            end
          end
        end
        ST_PUT: begin
          count <= count + CNT_W'(1);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid        = (state == ST_OUT);
  assign res.popped_key   = popped;
  assign res.was_empty    = empty;
  assign res.push_dropped = dropped;
  assign res.occupancy    = OCC_W'(count);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("key count beyond capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> CNT_W'(ram_req.waddr) <= count)
    else $error("RAM write beyond the occupied cells");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.was_empty) |-> (count == '0 && res.popped_key == '0))
    else $error("empty pop with keys held or non-zero key");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.push_dropped) |-> count == CNT_W'(DEPTH))
    else $error("push dropped while queue not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> (count == $past(count)))
    else $error("count changed while idle");
`endif

endmodule
`default_nettype wire

// ===== src/sorted_min_priority_queue_top.sv =====
// Push: walks from the last key down to the slot, moving each larger key up one cell, then writes the key.
// Pop: one read and one move per cell over all keys held; a full push or an empty pop skips the walk.
// The result is registered in the output register; the sequencer takes one item at a time.
// The walk uses the single read port of the key RAM and one compare.
// Reset (rst, synchronous, active high) empties the queue; stored keys are not cleared.
// Top level of the sorted minimum priority queue. Depends on sqp_pkg, sqp_ram and sqp_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module sorted_min_priority_queue_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [6:0] station_number, [13:7] item_number
  input  wire logic        s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [13:0] popped_key, [18:14] occupancy
  output logic      [1:0]  m_axis_tuser    // [0] was_empty, [1] push_dropped
);
  import sqp_pkg::*;

  sqp_result_t      res;
  sqp_result_t      out_res;
  sqp_ram_req_t     ram_req;
  logic [KEY_W-1:0] ram_rdata;
  logic             res_valid;
  logic             res_ready;

  // the output register frees up in the same cycle its transfer completes
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  sqp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .op             (s_axis_tuser),
    .station_number (s_axis_tdata[FIELD_W-1:0]),
    .item_number    (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  // key cells, smallest key in cell 0
  sqp_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // hold the finished result until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {5'b0, out_res.occupancy, out_res.popped_key};
  assign m_axis_tuser = {out_res.push_dropped, out_res.was_empty};

endmodule
`default_nettype wire
